// ----- rtl/core/imm_pkg.sv -----
// imm_pkg: shared types and constants for the integer matrix multiply block.
// Request payload structs, controller-to-datapath command/status structs, codes.
// No dependencies.
package imm_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIM    = 8;
    localparam int DEF_ELEM_WIDTH = 16;

    // Fixed field widths of the ports
    localparam int IDX_FIELD_W = 3;
    localparam int VALUE_W     = 16;
    localparam int SUM_W       = 32;
    localparam int CMD_W       = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    // Request command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_LEN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_FIELD_W-1:0]  row;
        logic [IDX_FIELD_W-1:0]  col;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0]  out_row;
        logic [IDX_FIELD_W-1:0]  out_col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } out_item_t;

    // Controller -> datapath
    typedef struct packed {
        logic                   wr_a;
        logic                   wr_b;
        logic                   issue;
        logic                   first_term;
        logic                   last_term;
        logic [IDX_FIELD_W-1:0] a_row;
        logic [IDX_FIELD_W-1:0] b_col;
        logic [IDX_FIELD_W-1:0] term;
        logic                   load_out;
        logic [IDX_FIELD_W-1:0] out_row;
        logic [IDX_FIELD_W-1:0] out_col;
        logic                   out_last;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic sum_ready;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/imm_ctrl.sv -----
// imm_ctrl: sequencer for loads and the row/col/term walk of a product.
// Holds the dimension registers. Depends on imm_pkg.
module imm_ctrl #(
    parameter int MAX_DIM = imm_pkg::DEF_MAX_DIM,
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [imm_pkg::CMD_W-1:0]            s_cmd,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]      s_row,
    input  logic [imm_pkg::IDX_FIELD_W-1:0]      s_col,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imm_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [imm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  imm_pkg::dp_status_t                  status,
    output imm_pkg::dp_cmd_t                     dp_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [imm_pkg::CFG_DATA_W-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    logic [IDX_W-1:0] m_last_reg, n_last_reg, k_last_reg;
    logic [IDX_W-1:0] r_reg, c_reg, t_reg;
    logic             elem_last, term_last, in_range;

    // Last index in use; 0 acts as 1, oversize clamps to MAX_DIM
    function automatic logic [IDX_W-1:0] last_idx(input logic [imm_pkg::CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return '0;
        end else if (v > imm_pkg::CFG_DATA_W'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(v - 1'b1);
        end
    endfunction

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign elem_last = (r_reg == m_last_reg) && (c_reg == k_last_reg);
    assign term_last = (t_reg == n_last_reg);
    assign in_range  = ({1'b0, s_row} < imm_pkg::CFG_DATA_W'(MAX_DIM))
                    && ({1'b0, s_col} < imm_pkg::CFG_DATA_W'(MAX_DIM));

    always_comb begin
        state_next        = state_reg;
        dp_cmd            = '0;
        dp_cmd.a_row      = imm_pkg::IDX_FIELD_W'(r_reg);
        dp_cmd.b_col      = imm_pkg::IDX_FIELD_W'(c_reg);
        dp_cmd.term       = imm_pkg::IDX_FIELD_W'(t_reg);
        dp_cmd.first_term = (t_reg == '0);
        dp_cmd.last_term  = term_last;
        dp_cmd.out_row    = imm_pkg::IDX_FIELD_W'(r_reg);
        dp_cmd.out_col    = imm_pkg::IDX_FIELD_W'(c_reg);
        dp_cmd.out_last   = elem_last;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_cmd)
                        imm_pkg::CMD_WRITE_A: dp_cmd.wr_a = in_range;
                        imm_pkg::CMD_WRITE_B: dp_cmd.wr_b = in_range;
                        imm_pkg::CMD_COMPUTE: state_next = ST_ISSUE;
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: begin
                dp_cmd.issue = 1'b1;
                if (term_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.sum_ready && status.out_free) begin
                    dp_cmd.load_out = 1'b1;
                    state_next      = elem_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rows_a_reg    <= imm_pkg::DIM_RESET;
            inner_len_reg <= imm_pkg::DIM_RESET;
            cols_b_reg    <= imm_pkg::DIM_RESET;
            m_last_reg    <= '0;
            n_last_reg    <= '0;
            k_last_reg    <= '0;
            r_reg         <= '0;
            c_reg         <= '0;
            t_reg         <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    imm_pkg::CFG_ROWS_A:    rows_a_reg    <= cfg_data;
                    imm_pkg::CFG_INNER_LEN: inner_len_reg <= cfg_data;
                    imm_pkg::CFG_COLS_B:    cols_b_reg    <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_cmd == imm_pkg::CMD_COMPUTE) begin
                        m_last_reg <= last_idx(rows_a_reg);
                        n_last_reg <= last_idx(inner_len_reg);
                        k_last_reg <= last_idx(cols_b_reg);
                        r_reg      <= '0;
                        c_reg      <= '0;
                        t_reg      <= '0;
                    end
                end
                ST_ISSUE: begin
                    t_reg <= term_last ? '0 : t_reg + 1'b1;
                end
                ST_DRAIN: begin
                    // row-major walk, advanced as each element is handed out
                    if (status.sum_ready && status.out_free && !elem_last) begin
                        if (c_reg == k_last_reg) begin
                            c_reg <= '0;
                            r_reg <= r_reg + 1'b1;
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- rtl/core/imm_dp.sv -----
// imm_dp: element stores, multiply-accumulate pipeline and result register.
// Driven by imm_ctrl commands. Depends on imm_pkg.
module imm_dp #(
    parameter int MAX_DIM    = imm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = imm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  imm_pkg::in_item_t    s_payload,
    input  imm_pkg::dp_cmd_t     cmd,
    output imm_pkg::dp_status_t  status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output imm_pkg::out_item_t   m_payload
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;

    logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
    logic [ELEM_WIDTH-1:0] b_mem [DEPTH];

    logic [ELEM_WIDTH-1:0]         wr_elem;
    logic [ADDR_W-1:0]             wr_addr, a_rd_addr, b_rd_addr;
    logic [ELEM_WIDTH-1:0]         a_rd_reg, b_rd_reg;
    logic signed [ELEM_WIDTH-1:0]  a_s, b_s;
    logic signed [PROD_W-1:0]      prod_full;
    logic [imm_pkg::SUM_W-1:0]     prod32, prod_reg, acc_reg;
    logic                          v1_reg, first1_reg, last1_reg;
    logic                          v2_reg, first2_reg, last2_reg;
    logic                          sum_ready_reg, m_valid_reg;
    imm_pkg::out_item_t            m_payload_reg;

    function automatic logic [ADDR_W-1:0] addr_of(
        input logic [imm_pkg::IDX_FIELD_W-1:0] r,
        input logic [imm_pkg::IDX_FIELD_W-1:0] c
    );
        return ADDR_W'(int'(r) * MAX_DIM + int'(c));
    endfunction

    // Element taken from the low bits of the 16-bit field, or zero-extended from it when wider
    if (ELEM_WIDTH <= imm_pkg::VALUE_W) begin : g_elem_narrow
        assign wr_elem = s_payload.value[ELEM_WIDTH-1:0];
    end else begin : g_elem_wide
        assign wr_elem = {{(ELEM_WIDTH - imm_pkg::VALUE_W){1'b0}}, s_payload.value};
    end

    assign wr_addr   = addr_of(s_payload.row, s_payload.col);
    assign a_rd_addr = addr_of(cmd.a_row, cmd.term);
    assign b_rd_addr = addr_of(cmd.term, cmd.b_col);

    always_ff @(posedge aclk) begin
        if (cmd.wr_a) begin
            a_mem[wr_addr] <= wr_elem;
        end
        if (cmd.wr_b) begin
            b_mem[wr_addr] <= wr_elem;
        end
        a_rd_reg <= a_mem[a_rd_addr];
        b_rd_reg <= b_mem[b_rd_addr];
    end

    assign a_s       = a_rd_reg;
    assign b_s       = b_rd_reg;
    assign prod_full = a_s * b_s;

    // Wrap or sign-extend the product to the 32-bit accumulator
    if (PROD_W >= imm_pkg::SUM_W) begin : g_prod_wrap
        assign prod32 = prod_full[imm_pkg::SUM_W-1:0];
    end else begin : g_prod_ext
        assign prod32 = imm_pkg::SUM_W'(prod_full);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod32;
        if (v2_reg) begin
            acc_reg <= (first2_reg ? '0 : acc_reg) + prod_reg;
        end
        if (cmd.load_out) begin
            m_payload_reg.out_row <= cmd.out_row;
            m_payload_reg.out_col <= cmd.out_col;
            m_payload_reg.sum     <= acc_reg;
            m_payload_reg.last    <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            first1_reg    <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            first2_reg    <= 1'b0;
            last2_reg     <= 1'b0;
            sum_ready_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            v1_reg     <= cmd.issue;
            first1_reg <= cmd.first_term;
            last1_reg  <= cmd.last_term;
            v2_reg     <= v1_reg;
            first2_reg <= first1_reg;
            last2_reg  <= last1_reg;
            if (v2_reg && last2_reg) begin
                sum_ready_reg <= 1'b1;
            end else if (cmd.load_out) begin
                sum_ready_reg <= 1'b0;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sum_ready = sum_ready_reg;
    assign status.out_free  = !m_valid_reg || m_ready;
    assign m_valid          = m_valid_reg;
    assign m_payload        = m_payload_reg;

endmodule

// ----- rtl/core/integer_matrix_multiply_top.sv -----
// integer_matrix_multiply_top: C = A x B over element stores loaded by request.
// Instantiates imm_ctrl and imm_dp. Depends on imm_pkg.
//
//  channel  | ports                          | carries
//  ---------+--------------------------------+-------------------------------------
//  s_       | s_valid s_ready s_payload      | write A / write B / compute request
//  m_       | m_valid m_ready m_payload      | one element of C, last on the final
//  cfg_     | cfg_valid cfg_ready index data | rows_a, inner_len, cols_b
//
// Load requests leave the block idle. A compute request produces rows_a*cols_b
// results, each of inner_len terms issued at one MAC term per cycle through the
// store read, multiply and accumulate stages, plus the handoff.
// s_ready is low from a compute request until its last result is registered.
// A held result stalls the next handoff only. Reset: aresetn, synchronous.
module integer_matrix_multiply_top #(
    parameter int MAX_DIM    = imm_pkg::DEF_MAX_DIM,
    parameter int ELEM_WIDTH = imm_pkg::DEF_ELEM_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  imm_pkg::in_item_t                 s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output imm_pkg::out_item_t                m_payload,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [imm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    imm_pkg::dp_cmd_t    dp_cmd;
    imm_pkg::dp_status_t dp_status;

    imm_ctrl #(
        .MAX_DIM(MAX_DIM)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_payload.cmd),
        .s_row     (s_payload.row),
        .s_col     (s_payload.col),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (dp_status),
        .dp_cmd    (dp_cmd)
    );

    imm_dp #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

// ----- rtl/core/imm_checker.sv -----
// imm_checker: port-level assertions for integer_matrix_multiply_top.
// Bound to the top level below. Depends on imm_pkg.
module imm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input imm_pkg::in_item_t   s_payload,
    input logic                m_valid,
    input logic                m_ready,
    input imm_pkg::out_item_t  m_payload
);

    // No result survives reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result changed while stalled");

    // A compute request blocks further requests
    a_compute_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.cmd == imm_pkg::CMD_COMPUTE |=> !s_ready)
        else $error("request taken right after compute");

    // Loads leave the block ready for the next request
    a_load_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_payload.cmd == imm_pkg::CMD_WRITE_A
                            || s_payload.cmd == imm_pkg::CMD_WRITE_B) |=> s_ready)
        else $error("load request held the block busy");

    // Results only come out of a compute in progress
    a_result_from_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

endmodule

bind integer_matrix_multiply_top imm_checker u_imm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

// ----- verif/integer_matrix_multiply_top_tb.sv -----
// integer_matrix_multiply_top_tb: self-checking bench for integer_matrix_multiply_top.
// Runs a directed request table, then random load/compute sequences, against a predictor.
// Depends on imm_pkg and the integer_matrix_multiply_top RTL.
`timescale 1ns / 100ps

module integer_matrix_multiply_top_tb;

    localparam int DIM         = imm_pkg::DEF_MAX_DIM;
    localparam int STALL_LIMIT = 2000;
    localparam int DIR_STEPS   = 15;
    localparam int RAND_ITEMS  = 160;

    // unused command code, ignored by the block
    localparam logic [imm_pkg::CMD_W-1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        imm_pkg::in_item_t  req;
        logic               typed;
        logic signed [31:0] sum;
    } dir_step_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    imm_pkg::in_item_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    imm_pkg::out_item_t m_payload;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [imm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [imm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic signed [31:0] a_mirror [DIM*DIM];
    logic signed [31:0] b_mirror [DIM*DIM];
    bit                 a_known [DIM*DIM];
    bit                 b_known [DIM*DIM];
    logic [3:0]         rows_cfg = imm_pkg::DIM_RESET;
    logic [3:0]         inner_cfg = imm_pkg::DIM_RESET;
    logic [3:0]         cols_cfg = imm_pkg::DIM_RESET;
    imm_pkg::out_item_t product_q [$];

    int        mismatches = 0;
    int        item_total = 0;
    int        quiet_cycles = 0;
    bit        steady = 1'b0;
    dir_step_t dir_table [DIR_STEPS];

    integer_matrix_multiply_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic int eff_dim(logic [3:0] raw);
        if (raw == 4'd0) return 1;
        if (raw > 4'(DIM)) return DIM;
        return int'(raw);
    endfunction

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic dir_step_t dir_row(logic [imm_pkg::CMD_W-1:0] cmd, int r, int c,
                                          logic [15:0] v, logic typed,
                                          logic signed [31:0] sum);
        dir_step_t d;
        d.req.cmd   = cmd;
        d.req.row   = 3'(r);
        d.req.col   = 3'(c);
        d.req.value = v;
        d.typed     = typed;
        d.sum       = sum;
        return d;
    endfunction

    // row-major dot products over the current dimensions, 32-bit wrap
    task automatic predict_product();
        int m, n, k;
        logic signed [31:0] acc;
        imm_pkg::out_item_t e;
        m = eff_dim(rows_cfg);
        n = eff_dim(inner_cfg);
        k = eff_dim(cols_cfg);
        for (int r = 0; r < m; r++) begin
            for (int c = 0; c < k; c++) begin
                acc = '0;
                for (int t = 0; t < n; t++)
                    acc = acc + a_mirror[r*DIM+t] * b_mirror[t*DIM+c];
                e.out_row = 3'(r);
                e.out_col = 3'(c);
                e.sum     = acc;
                e.last    = (r == m-1 && c == k-1);
                product_q.push_back(e);
            end
        end
    endtask

    // one request; returns at the edge where it is accepted
    task automatic send_req(imm_pkg::in_item_t it, logic typed,
                            logic signed [31:0] typed_sum);
        int idx;
        imm_pkg::out_item_t e;
        if (!steady && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        idx = {it.row, it.col};
        case (it.cmd)
            imm_pkg::CMD_WRITE_A: begin
                a_mirror[idx] = $signed(it.value);
                a_known[idx]  = 1'b1;
            end
            imm_pkg::CMD_WRITE_B: begin
                b_mirror[idx] = $signed(it.value);
                b_known[idx]  = 1'b1;
            end
            imm_pkg::CMD_COMPUTE: begin
                if (typed) begin
                    e.out_row = '0;
                    e.out_col = '0;
                    e.sum     = typed_sum;
                    e.last    = 1'b1;
                    product_q.push_back(e);
                end else begin
                    predict_product();
                end
            end
            default: ;
        endcase
        if (it.cmd != CMD_NONE) item_total++;
    endtask

    // load request, sometimes preceded by an ignored request or a load to a random position
    task automatic send_load(logic [imm_pkg::CMD_W-1:0] cmd, int r, int c);
        imm_pkg::in_item_t it;
        if ($urandom_range(11) == 0) begin
            it.cmd   = CMD_NONE;
            it.row   = 3'($urandom);
            it.col   = 3'($urandom);
            it.value = rand_elem();
            send_req(it, 1'b0, '0);
        end
        if ($urandom_range(11) == 0) begin
            it.cmd   = $urandom_range(1) ? imm_pkg::CMD_WRITE_B : imm_pkg::CMD_WRITE_A;
            it.row   = 3'($urandom);
            it.col   = 3'($urandom);
            it.value = rand_elem();
            send_req(it, 1'b0, '0);
        end
        it.cmd   = cmd;
        it.row   = 3'(r);
        it.col   = 3'(c);
        it.value = rand_elem();
        send_req(it, 1'b0, '0);
    endtask

    // write the operands the product reads (missing ones always, known ones at random), then compute
    task automatic fill_and_compute();
        int m, n, k;
        imm_pkg::in_item_t it;
        m = eff_dim(rows_cfg);
        n = eff_dim(inner_cfg);
        k = eff_dim(cols_cfg);
        for (int r = 0; r < m; r++)
            for (int t = 0; t < n; t++)
                if (!a_known[r*DIM+t] || $urandom_range(3) == 0)
                    send_load(imm_pkg::CMD_WRITE_A, r, t);
        for (int t = 0; t < n; t++)
            for (int c = 0; c < k; c++)
                if (!b_known[t*DIM+c] || $urandom_range(3) == 0)
                    send_load(imm_pkg::CMD_WRITE_B, t, c);
        it.cmd   = imm_pkg::CMD_COMPUTE;
        it.row   = 3'($urandom);
        it.col   = 3'($urandom);
        it.value = rand_elem();
        send_req(it, 1'b0, '0);
    endtask

    // hold off until all results are in, then let trailing loads finish
    task automatic settle(int tail);
        s_valid <= 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_dims(logic [3:0] rows, logic [3:0] inner, logic [3:0] cols);
        logic [imm_pkg::CFG_INDEX_W-1:0] idx [3];
        logic [3:0]                      val [3];
        idx = '{imm_pkg::CFG_ROWS_A, imm_pkg::CFG_INNER_LEN, imm_pkg::CFG_COLS_B};
        val = '{rows, inner, cols};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        rows_cfg  = rows;
        inner_cfg = inner;
        cols_cfg  = cols;
    endtask

    // result checker and sink-side stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (product_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: row %0d col %0d sum %0d last %0b",
                             m_payload.out_row, m_payload.out_col, m_payload.sum,
                             m_payload.last);
            end else begin
                if (m_payload.out_row != product_q[0].out_row ||
                    m_payload.out_col != product_q[0].out_col ||
                    m_payload.sum     != product_q[0].sum ||
                    m_payload.last    != product_q[0].last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp r%0d c%0d sum %0d last %0b, ",
                                  "got r%0d c%0d sum %0d last %0b"},
                                 product_q[0].out_row, product_q[0].out_col,
                                 product_q[0].sum, product_q[0].last,
                                 m_payload.out_row, m_payload.out_col,
                                 m_payload.sum, m_payload.last);
                end
                void'(product_q.pop_front());
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 31);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        logic [3:0] d [3];
        // dims written as 0 act as 1x1x1, so every product is a single element
        dir_table[0]  = dir_row(imm_pkg::CMD_WRITE_A, 0, 0, 16'h8000, 1'b0, '0);
        dir_table[1]  = dir_row(imm_pkg::CMD_WRITE_B, 0, 0, 16'h8000, 1'b0, '0);
        dir_table[2]  = dir_row(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, 32'sh4000_0000);
        dir_table[3]  = dir_row(imm_pkg::CMD_WRITE_A, 0, 0, 16'h7fff, 1'b0, '0);
        dir_table[4]  = dir_row(imm_pkg::CMD_WRITE_B, 0, 0, 16'h7fff, 1'b0, '0);
        dir_table[5]  = dir_row(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, 32'sh3fff_0001);
        dir_table[6]  = dir_row(imm_pkg::CMD_WRITE_B, 0, 0, 16'h8000, 1'b0, '0);
        dir_table[7]  = dir_row(CMD_NONE, 7, 7, 16'hffff, 1'b0, '0);
        // compute ignores its row, col and value fields
        dir_table[8]  = dir_row(imm_pkg::CMD_COMPUTE, 7, 7, 16'hffff, 1'b1, 32'shc000_8000);
        dir_table[9]  = dir_row(imm_pkg::CMD_WRITE_A, 7, 7, 16'hffff, 1'b0, '0);
        dir_table[10] = dir_row(imm_pkg::CMD_WRITE_B, 7, 0, 16'h0001, 1'b0, '0);
        dir_table[11] = dir_row(imm_pkg::CMD_WRITE_A, 0, 0, 16'hffff, 1'b0, '0);
        dir_table[12] = dir_row(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, 32'sh0000_8000);
        dir_table[13] = dir_row(imm_pkg::CMD_WRITE_B, 0, 0, 16'h0000, 1'b0, '0);
        dir_table[14] = dir_row(imm_pkg::CMD_COMPUTE, 0, 0, 16'h0000, 1'b1, 32'sh0000_0000);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_dims(4'd0, 4'd0, 4'd0);
        for (int i = 0; i < DIR_STEPS; i++)
            send_req(dir_table[i].req, dir_table[i].typed, dir_table[i].sum);
        settle(16);

        item_total = 0;
        phase = 0;
        while (phase < 4 || item_total < RAND_ITEMS) begin
            case (phase)
                0: d = '{4'd15, 4'd15, 4'd1};
                1: d = '{4'd9, 4'd1, 4'd15};
                2: d = '{4'd1, 4'd8, 4'd1};
                default: begin
                    for (int j = 0; j < 3; j++)
                        d[j] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                        : 4'($urandom_range(4));
                end
            endcase
            write_dims(d[0], d[1], d[2]);
            steady = (phase == 3);
            repeat ((phase == 3) ? 3 : $urandom_range(1, 3)) begin
                fill_and_compute();
                // sender sometimes holds off until the product drains
                if ($urandom_range(2) == 0) settle(0);
            end
            settle(16);
            steady = 1'b0;
            phase++;
        end

        settle(30);
        if (mismatches == 0 && product_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/imm_pkg.sv
rtl/core/imm_ctrl.sv
rtl/core/imm_dp.sv
rtl/core/integer_matrix_multiply_top.sv
rtl/core/imm_checker.sv
verif/integer_matrix_multiply_top_tb.sv
